/* hdl/rldeq_pkg.sv */
// Shared types and constants for the run-length deque block.
// Depends on nothing; imported by the top level and its checker.
package rldeq_pkg;

  localparam int unsigned RUN_SLOTS = 256;
  localparam int unsigned SLOT_W    = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int unsigned RUNS_W    = $clog2(RUN_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_REV = 2'd2
  } op_e;

  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] item_value;
    logic        [31:0] item_count;
  } in_beat_t;

  typedef struct packed {
    logic               answer_kind;
    logic        [31:0] element_total_out;
    logic signed [31:0] end_value;
    logic               full_flag;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] count;
  } run_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(RUN_SLOTS - 1)) r = '0;
    else r = s + SLOT_W'(1);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) r = SLOT_W'(RUN_SLOTS - 1);
    else r = s - SLOT_W'(1);
    return r;
  endfunction

endpackage

/* hdl/run_length_deque_with_reverse.sv */
// Top level of the run-length deque: run ring memory, sequencer and shared adder.
// Depends on rldeq_pkg.
//
// Usage: one input channel (in_valid_i/in_ready_o/in_beat_i) carries add, delete
// and reverse commands; one output channel (out_valid_o/out_ready_i/out_beat_o)
// carries one result beat per add or delete. A reverse beat gives no result.
// in_ready_o is high only while the sequencer is idle; one item is worked at a
// time through a single 33-bit add/subtract unit and a ring memory with one
// write port and one registered read port.
// Sequence from accept to result, with the output register free:
//   reverse: no result; ready again in the next cycle.
//   add: S_ADD, then S_OUT (straight to S_OUT for a zero count or a full ring).
//   delete: straight to S_OUT on an empty queue, else S_RD, S_CMP, S_WANT, S_TOT per fully
//   consumed run and S_RD, S_CMP, S_TOT for a run that is shortened or left whole, then S_OUT.
// The next item is accepted in the cycle after the result lands in the output
// register. If the receiver stalls, the finished result waits in the output
// stage and the next result is held until that beat is taken.
// Reset clears the ring pointers, run count, element total and reversed flag;
// the ring memory needs no clearing since only live slots are read.
module run_length_deque_with_reverse
  import rldeq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADD  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_WANT = 7'b0010000,
    S_TOT  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] front_q, front_d, back_q, back_d;
  logic [RUNS_W-1:0] runs_q, runs_d;
  logic [31:0]       total_q, total_d;
  logic              rev_q, rev_d;
  logic              first_q, first_d;
  op_e               op_q, op_d;
  logic [31:0]       val_q, val_d, want_q, want_d, diff_q, diff_d, endv_q, endv_d;
  logic              le_q, le_d, full_q, full_d;
  logic              out_valid_q;
  out_beat_t         out_q;

  run_t              mem [RUN_SLOTS];
  run_t              rd_q, mem_wd;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa, rd_slot, add_slot;

  logic [31:0]       alu_a, alu_b;
  logic              alu_sub;
  logic [32:0]       alu_r;
  logic              load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign rd_slot     = rev_q ? front_q : back_q;
  assign load_out    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign alu_r = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_slot];
  end

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    back_d   = back_q;
    runs_d   = runs_q;
    total_d  = total_q;
    rev_d    = rev_q;
    first_d  = first_q;
    op_d     = op_q;
    val_d    = val_q;
    want_d   = want_q;
    diff_d   = diff_q;
    endv_d   = endv_q;
    le_d     = le_q;
    full_d   = full_q;
    mem_we   = 1'b0;
    mem_wa   = rd_slot;
    mem_wd   = '{value: rd_q.value, count: diff_q};
    alu_a    = total_q;
    alu_b    = want_q;
    alu_sub  = 1'b0;
    add_slot = front_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_beat_i.operation;
          val_d   = in_beat_i.item_value;
          want_d  = in_beat_i.item_count;
          full_d  = 1'b0;
          first_d = 1'b1;
          endv_d  = '0;
          case (in_beat_i.operation)
            OP_ADD: begin
              if (in_beat_i.item_count == '0) begin
                state_d = S_OUT;
              end else if (runs_q == RUNS_W'(RUN_SLOTS)) begin
                full_d  = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_ADD;
              end
            end
            OP_DEL: begin
              state_d = (runs_q == '0) ? S_OUT : S_RD;
            end
            default: begin
              rev_d = ~rev_q;
            end
          endcase
        end
      end
      S_ADD: begin
        total_d = alu_r[31:0];
        if (runs_q == '0) begin
          add_slot = front_q;
          back_d   = front_q;
        end else if (!rev_q) begin
          add_slot = slot_prev(front_q);
          front_d  = add_slot;
        end else begin
          add_slot = slot_next(back_q);
          back_d   = add_slot;
        end
        mem_we  = 1'b1;
        mem_wa  = add_slot;
        mem_wd  = '{value: val_q, count: want_q};
        runs_d  = runs_q + RUNS_W'(1);
        state_d = S_OUT;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        alu_a   = rd_q.count;
        alu_b   = want_q;
        alu_sub = 1'b1;
        diff_d  = alu_r[31:0];
        le_d    = alu_r[32] || (alu_r[31:0] == '0);
        if (first_q) begin
          endv_d  = rd_q.value;
          first_d = 1'b0;
        end
        state_d = (alu_r[32] || (alu_r[31:0] == '0)) ? S_WANT : S_TOT;
      end
      S_WANT: begin
        alu_a   = want_q;
        alu_b   = rd_q.count;
        alu_sub = 1'b1;
        want_d  = alu_r[31:0];
        state_d = S_TOT;
      end
      S_TOT: begin
        alu_a   = total_q;
        alu_b   = le_q ? rd_q.count : want_q;
        alu_sub = 1'b1;
        total_d = alu_r[31:0];
        if (le_q) begin
          runs_d = runs_q - RUNS_W'(1);
          if (runs_q != RUNS_W'(1)) begin
            if (rev_q) front_d = slot_next(front_q);
            else back_d = slot_prev(back_q);
          end
          state_d = ((want_q == '0) || (runs_q == RUNS_W'(1))) ? S_OUT : S_RD;
        end else begin
          mem_we  = 1'b1;
          want_d  = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      runs_q      <= '0;
      total_q     <= '0;
      rev_q       <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      runs_q  <= runs_d;
      total_q <= total_d;
      rev_q   <= rev_d;
      first_q <= first_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    val_q  <= val_d;
    want_q <= want_d;
    diff_q <= diff_d;
    endv_q <= endv_d;
    le_q   <= le_d;
    full_q <= full_d;
    if (load_out) begin
      if (op_q == OP_DEL) begin
        out_q.answer_kind       <= KIND_END;
        out_q.element_total_out <= '0;
        out_q.end_value         <= endv_q;
        out_q.full_flag         <= 1'b0;
      end else begin
        out_q.answer_kind       <= KIND_TOTAL;
        out_q.element_total_out <= total_q;
        out_q.end_value         <= '0;
        out_q.full_flag         <= full_q;
      end
    end
  end

endmodule

/* hdl/rldeq_checker.sv */
// Port-level checker for the run-length deque and its bind to the top level.
// Depends on rldeq_pkg and run_length_deque_with_reverse.
module rldeq_checker
  import rldeq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_beat_i.operation == OP_ADD || in_beat_i.operation == OP_DEL) |=> !in_ready_o)
    else $error("ready held after an add or delete beat");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.answer_kind == KIND_END |->
    out_beat_o.element_total_out == '0 && !out_beat_o.full_flag)
    else $error("delete result carries add fields");

  a_total_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.answer_kind == KIND_TOTAL |-> out_beat_o.end_value == '0)
    else $error("add result carries an end value");

  a_rev_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    !(in_beat_i.operation == OP_ADD || in_beat_i.operation == OP_DEL) |=> !out_valid_o)
    else $error("reverse beat produced a result");

endmodule

bind run_length_deque_with_reverse rldeq_checker u_rldeq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

/* sim/run_length_deque_with_reverse_test.sv */
// Self-checking testbench for run_length_deque_with_reverse: a directed table, a fill past
// capacity, then random add, delete and reverse beats, checked against a behavioral deque predictor.
// Depends on rldeq_pkg and the top level only.
module run_length_deque_with_reverse_test;
  import rldeq_pkg::*;

  localparam op_e         OP_SPARE     = op_e'(2'd3);
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned FILL_ITEMS   = 300;
  localparam int unsigned ITEM_TARGET  = 1850;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PLAN_ROWS    = 22;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t answer;
  } plan_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  logic [31:0]       dq_val [RUN_SLOTS];
  logic [31:0]       dq_cnt [RUN_SLOTS];
  logic [SLOT_W-1:0] dq_front = '0;
  logic [SLOT_W-1:0] dq_back  = '0;
  logic [RUNS_W-1:0] dq_runs  = '0;
  logic [31:0]       dq_total = '0;
  logic              dq_rev   = 1'b0;

  out_beat_t   pending_answers [$];
  int unsigned items_sent   = 0;
  int unsigned answers_seen = 0;
  int unsigned refused_adds = 0;
  int unsigned peak_runs    = 0;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  bit          no_idle      = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_DEL,    32'sd0,           32'd5},           1'b1, '{KIND_END,   32'd0, 32'sd0, 1'b0}},
    '{'{OP_ADD,    32'sh7FFF_FFFF,   32'd0},           1'b1, '{KIND_TOTAL, 32'd0, 32'sd0, 1'b0}},
    '{'{OP_REV,    32'shFFFF_FFFF,   32'hFFFF_FFFF},   1'b0, '0},
    '{'{OP_ADD,    32'sh8000_0000,   32'd3},           1'b1, '{KIND_TOTAL, 32'd3, 32'sd0, 1'b0}},
    '{'{OP_ADD,    32'shFFFF_FFFF,   32'hFFFF_FFFF},   1'b1, '{KIND_TOTAL, 32'd2, 32'sd0, 1'b0}},
    '{'{OP_DEL,    32'sh1234_5678,   32'd0},           1'b0, '0},
    '{'{OP_SPARE,  32'sd0,           32'd0},           1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'd1},           1'b0, '0},
    '{'{OP_ADD,    32'sd1,           32'd1},           1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'hFFFF_FFFF},   1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'hFFFF_FFFF},   1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'd7},           1'b1, '{KIND_END,   32'd0, 32'sd0, 1'b0}},
    '{'{OP_ADD,    32'sh5555_5555,   32'h8000_0000},   1'b1,
      '{KIND_TOTAL, 32'h8000_0000, 32'sd0, 1'b0}},
    '{'{OP_ADD,    32'shAAAA_AAAA,   32'h8000_0000},   1'b1, '{KIND_TOTAL, 32'd0, 32'sd0, 1'b0}},
    '{'{OP_REV,    32'sd0,           32'd0},           1'b0, '0},
    '{'{OP_ADD,    32'sd0,           32'd1},           1'b1, '{KIND_TOTAL, 32'd1, 32'sd0, 1'b0}},
    '{'{OP_DEL,    32'sd0,           32'h8000_0000},   1'b0, '0},
    '{'{OP_SPARE,  32'shFFFF_FFFF,   32'hFFFF_FFFF},   1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'd0},           1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'h7FFF_FFFF},   1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'd2},           1'b0, '0},
    '{'{OP_DEL,    32'sd0,           32'd1},           1'b0, '0}
  };

  run_length_deque_with_reverse u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [SLOT_W-1:0] ring_fwd(input logic [SLOT_W-1:0] s);
    return SLOT_W'((int'(s) + 1) % int'(RUN_SLOTS));
  endfunction

  function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] s);
    return SLOT_W'((int'(s) + int'(RUN_SLOTS) - 1) % int'(RUN_SLOTS));
  endfunction

  function automatic bit deque_step(input in_beat_t b, output out_beat_t r);
    logic [SLOT_W-1:0] s;
    logic [31:0]       want;
    r = '0;
    if (b.operation == OP_ADD) begin
      r.answer_kind = KIND_TOTAL;
      if (b.item_count != '0) begin
        if (dq_runs >= RUN_SLOTS) begin
          r.full_flag = 1'b1;
        end else begin
          if (dq_runs == '0) begin
            s = dq_front;
            dq_back = s;
          end else if (!dq_rev) begin
            s = ring_back(dq_front);
            dq_front = s;
          end else begin
            s = ring_fwd(dq_back);
            dq_back = s;
          end
          dq_val[s] = b.item_value;
          dq_cnt[s] = b.item_count;
          dq_runs   = dq_runs + 1'b1;
          dq_total  = dq_total + b.item_count;
        end
      end
      r.element_total_out = dq_total;
      return 1'b1;
    end
    if (b.operation == OP_DEL) begin
      r.answer_kind = KIND_END;
      if (dq_runs != '0) r.end_value = dq_val[dq_rev ? dq_front : dq_back];
      want = b.item_count;
      while (want != '0 && dq_runs != '0) begin
        s = dq_rev ? dq_front : dq_back;
        if (dq_cnt[s] <= want) begin
          want     = want - dq_cnt[s];
          dq_total = dq_total - dq_cnt[s];
          dq_runs  = dq_runs - 1'b1;
          if (dq_runs != '0) begin
            if (dq_rev) dq_front = ring_fwd(s);
            else dq_back = ring_back(s);
          end
        end else begin
          dq_cnt[s] = dq_cnt[s] - want;
          dq_total  = dq_total - want;
          want      = '0;
        end
      end
      return 1'b1;
    end
    dq_rev = ~dq_rev;
    return 1'b0;
  endfunction

  function automatic in_beat_t random_beat(input mix_e mix);
    in_beat_t    b;
    int unsigned pick;
    int unsigned sel;
    int unsigned add_w;
    int unsigned del_w;
    b.item_value = $urandom;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        add_w = 85;
        del_w = 8;
      end
      MIX_DRAIN: begin
        add_w = 25;
        del_w = 67;
      end
      default: begin
        add_w = 46;
        del_w = 46;
      end
    endcase
    if (pick < add_w) begin
      b.operation = OP_ADD;
      if (sel < 5) b.item_count = '0;
      else if (sel < 10) b.item_count = $urandom;
      else if (sel < 13) b.item_count = 32'hFFFF_FFFF - $urandom_range(7);
      else b.item_count = $urandom_range(16, 1);
    end else if (pick < add_w + del_w) begin
      b.operation = OP_DEL;
      if (sel < 6) b.item_count = '0;
      else if (sel < 16) b.item_count = $urandom;
      else if (sel < 30) b.item_count = $urandom_range(200);
      else b.item_count = $urandom_range(12);
    end else begin
      b.operation  = (pick == 99) ? OP_SPARE : OP_REV;
      b.item_count = $urandom;
    end
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t answer);
    int unsigned gap;
    out_beat_t   r;
    gap = no_idle ? 0 : $urandom_range(9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (deque_step(b, r)) begin
      pending_answers.push_back(typed ? answer : r);
      if (r.full_flag) refused_adds++;
    end
    if (dq_runs > peak_runs) peak_runs = dq_runs;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  initial begin : stimulus
    in_beat_t    b;
    mix_e        mix;
    int unsigned span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].answer);
    wait_drained();

    // fill the ring past capacity; the receiver's long hold-off comes during this fill
    for (int i = 0; i < FILL_ITEMS; i++) begin
      b.operation  = ($urandom_range(19) == 0) ? OP_REV : OP_ADD;
      b.item_value = $urandom;
      b.item_count = $urandom_range(8, 1);
      send_beat(b, 1'b0, '0);
    end
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      mix     = mix_e'($urandom_range(2));
      no_idle = ($urandom_range(3) == 0);
      span    = $urandom_range(200, 60);
      if (span > ITEM_TARGET - items_sent) span = ITEM_TARGET - items_sent;
      repeat (span) send_beat(random_beat(mix), 1'b0, '0);
      no_idle = 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_answers.size());
      fail_count++;
    end
    $display("Covered %0d input beats and %0d result beats, %0d adds refused on a full ring,",
             items_sent, answers_seen, refused_adds);
    $display("peak of %0d runs held, with random gaps, stalls and one long output hold-off.",
             peak_runs);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : answer_sink
    int unsigned stall;
    out_beat_t   want;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(9);
      if (answers_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result beat with no expectation pending: %p", out_beat_o);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_beat_o.answer_kind !== want.answer_kind) begin
          $error("answer_kind: expected %0d, got %0d", want.answer_kind, out_beat_o.answer_kind);
          fail_count++;
        end
        if (out_beat_o.element_total_out !== want.element_total_out) begin
          $error("element_total_out: expected %0d, got %0d",
                 want.element_total_out, out_beat_o.element_total_out);
          fail_count++;
        end
        if (out_beat_o.end_value !== want.end_value) begin
          $error("end_value: expected %0d, got %0d", want.end_value, out_beat_o.end_value);
          fail_count++;
        end
        if (out_beat_o.full_flag !== want.full_flag) begin
          $error("full_flag: expected %0d, got %0d", want.full_flag, out_beat_o.full_flag);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
